FILE: hw/rtl/sesstab_pkg.sv
// ----------------------------------------------------------------------------
// sesstab_pkg: shared types and constants of the session slot table
// widths, request and status codes, register indexes and the result record
// ----------------------------------------------------------------------------
package sesstab_pkg;

  // table geometry
  localparam int SESSION_SLOTS = 4;
  localparam int SLOT_W        = 2;
  localparam int CNT_W         = $clog2(SESSION_SLOTS + 1);

  // field widths
  localparam int REQ_W      = 3;
  localparam int HANDLE_W   = 64;
  localparam int OWNER_W    = 32;
  localparam int TIME_W     = 64;
  localparam int TIMEOUT_W  = 32;
  localparam int SHIFT_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register reset values: two minutes of idle age, tag at or above bit 32
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(120 * 1000);
  localparam logic [SHIFT_W-1:0]   SHIFT_RESET   = SHIFT_W'(32);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SHIFT = 1'd1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CREATE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_HANDLE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_OWNER  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_HANDLE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BUSY       = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NOT_BUSY   = 3'd5;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CREATE
  } state_t;

  // one result record
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                abort_valid;
    logic [HANDLE_W-1:0] abort_handle;
    logic                last;
  } result_t;

  // build a result record
  function automatic result_t make_res(input logic [STATUS_W-1:0] status,
                                       input logic [SLOT_W-1:0]   slot,
                                       input logic                abort_valid,
                                       input logic [HANDLE_W-1:0] abort_handle,
                                       input logic                last);
    result_t r;
    r.status       = status;
    r.slot         = slot;
    r.abort_valid  = abort_valid;
    r.abort_handle = abort_handle;
    r.last         = last;
    return r;
  endfunction

endpackage

FILE: hw/rtl/session_slot_table_timeout_evict.sv
// ----------------------------------------------------------------------------
// session_slot_table_timeout_evict: session table with timeout eviction
// four session slots kept in age order, scanned one slot per cycle unless the output
// stalls, by a shared compare unit (handle, owner and 65-bit timeout compare)
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in_      | input     | in_valid / in_stall     | req_type, handle, owner, time
//  out_     | output    | out_valid / out_stall   | status, slot, abort, last
//  cfg_     | input     | cfg_wr_en (no wait)     | cfg_index, cfg_wdata
//
// a request is captured in idle and dispatched, then the single compare unit walks
// the slots in age order (up to four); a closing result or a store step may follow.
// reset (rst_n low, synchronous) frees all slots and restores the registers.
// in_stall is high while a request is in work; the sequencer holds whenever
// the output register is full and stalled, so results are never dropped.
//
module session_slot_table_timeout_evict (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sesstab_pkg::REQ_W-1:0]         in_req_type,
  input  logic [sesstab_pkg::HANDLE_W-1:0]      in_handle,
  input  logic [sesstab_pkg::OWNER_W-1:0]       in_owner_user,
  input  logic [sesstab_pkg::OWNER_W-1:0]       in_owner_uid,
  input  logic [sesstab_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [sesstab_pkg::SLOT_W-1:0]        in_release_slot,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sesstab_pkg::STATUS_W-1:0]      out_status,
  output logic [sesstab_pkg::SLOT_W-1:0]        out_slot,
  output logic                                  out_abort_valid,
  output logic [sesstab_pkg::HANDLE_W-1:0]      out_abort_handle,
  output logic                                  out_last,
  // configuration port
  input  logic                                  cfg_wr_en,
  input  logic [sesstab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sesstab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import sesstab_pkg::*;

  // sequencer and registers
  state_t                 state_r, state_nxt;
  logic [TIMEOUT_W-1:0]   timeout_r;
  logic [SHIFT_W-1:0]     shift_r;

  // captured request
  logic [REQ_W-1:0]       req_r;
  logic [HANDLE_W-1:0]    handle_r;
  logic [OWNER_W-1:0]     user_r;
  logic [OWNER_W-1:0]     uid_r;
  logic [TIME_W-1:0]      now_r;
  logic [SLOT_W-1:0]      rel_r;
  logic                   hok_r;
  logic                   hok_in;

  // slot state
  logic [SESSION_SLOTS-1:0] valid_r;
  logic [SESSION_SLOTS-1:0] busy_r;
  logic [SLOT_W-1:0]        rank_r       [SESSION_SLOTS];
  logic [HANDLE_W-1:0]      ent_handle_r [SESSION_SLOTS];
  logic [OWNER_W-1:0]       ent_user_r   [SESSION_SLOTS];
  logic [OWNER_W-1:0]       ent_uid_r    [SESSION_SLOTS];
  logic [TIME_W-1:0]        ent_start_r  [SESSION_SLOTS];
  logic [CNT_W-1:0]         live_r;

  // scan bookkeeping
  logic [CNT_W-1:0]       cur_r;
  logic                   saw_busy_r;
  logic                   pend_valid_r;
  logic [SLOT_W-1:0]      pend_slot_r;
  logic [HANDLE_W-1:0]    pend_handle_r;
  logic                   ev_valid_r;
  logic [HANDLE_W-1:0]    ev_handle_r;

  // output register
  logic                   out_valid_r;
  result_t                out_r;

  // compare unit signals
  logic [SLOT_W-1:0]      scan_slot;
  logic [SLOT_W-1:0]      free_slot;
  logic [HANDLE_W-1:0]    s_handle;
  logic [OWNER_W-1:0]     s_user;
  logic [OWNER_W-1:0]     s_uid;
  logic [TIME_W-1:0]      s_start;
  logic                   s_busy;
  logic [TIME_W:0]        tmo_sum;
  logic                   own_eq;
  logic                   hdl_eq;
  logic                   timed_out;
  logic                   cr_hit;
  logic                   acq_match;
  logic                   own_hit;
  logic                   scan_end;
  logic                   live_full;
  logic                   rel_ok;
  logic                   out_space;

  // actions
  logic                   emit;
  result_t                emit_res;
  logic                   do_remove;
  logic                   do_create;
  logic                   do_acquire;
  logic                   do_release;
  logic                   cur_inc;
  logic                   scan_init;
  logic                   set_saw_busy;
  logic                   pend_load;
  logic                   ev_load;

  // handle tag check: any bit at or above the shift amount set
  always_comb begin
    hok_in = 1'b0;
    for (int i = 0; i < HANDLE_W; i++) begin
      if ((i >= int'(shift_r)) && in_handle[i]) begin
        hok_in = 1'b1;
      end
    end
  end

  // slot holding the current age rank
  always_comb begin
    scan_slot = '0;
    for (int s = 0; s < SESSION_SLOTS; s++) begin
      if (valid_r[s] && (rank_r[s] == cur_r[SLOT_W-1:0])) begin
        scan_slot = SLOT_W'(s);
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int s = SESSION_SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free_slot = SLOT_W'(s);
      end
    end
  end

  // shared compare unit on the scanned slot
  assign s_handle  = ent_handle_r[scan_slot];
  assign s_user    = ent_user_r[scan_slot];
  assign s_uid     = ent_uid_r[scan_slot];
  assign s_start   = ent_start_r[scan_slot];
  assign s_busy    = busy_r[scan_slot];
  assign own_eq    = (s_user == user_r) && (s_uid == uid_r);
  assign hdl_eq    = (s_handle == handle_r);
  assign tmo_sum   = {1'b0, s_start} + {{(TIME_W + 1 - TIMEOUT_W){1'b0}}, timeout_r};
  assign timed_out = (tmo_sum < {1'b0, now_r});

  assign cr_hit    = !s_busy && (own_eq || timed_out);
  assign acq_match = hdl_eq && own_eq;
  assign own_hit   = !s_busy && own_eq;
  assign scan_end  = !(cur_r < live_r);
  assign live_full = (live_r >= CNT_W'(SESSION_SLOTS));
  assign rel_ok    = ({1'b0, rel_r} < CNT_W'(SESSION_SLOTS)) && valid_r[rel_r];
  assign out_space = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (out_space) begin
          case (req_r) inside
            REQ_CREATE: begin
              if (!hok_r)         state_nxt = S_IDLE;
              else if (live_full) state_nxt = S_SCAN;
              else                state_nxt = S_CREATE;
            end
            REQ_ACQUIRE, REQ_DEL_HANDLE: begin
              state_nxt = hok_r ? S_SCAN : S_IDLE;
            end
            REQ_DEL_OWNER: state_nxt = S_SCAN;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (out_space) begin
          if (scan_end) begin
            state_nxt = S_IDLE;
          end else begin
            case (req_r)
              REQ_CREATE:     if (cr_hit) state_nxt = S_CREATE;
              REQ_ACQUIRE:    if (acq_match && !s_busy) state_nxt = S_IDLE;
              REQ_DEL_HANDLE: if (hdl_eq) state_nxt = S_IDLE;
              default:        state_nxt = state_r;
            endcase
          end
        end
      end
      S_CREATE: begin
        if (out_space) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer actions and result selection
  always_comb begin
    emit         = 1'b0;
    emit_res     = make_res(STAT_OK, '0, 1'b0, '0, 1'b1);
    do_remove    = 1'b0;
    do_create    = 1'b0;
    do_acquire   = 1'b0;
    do_release   = 1'b0;
    cur_inc      = 1'b0;
    scan_init    = 1'b0;
    set_saw_busy = 1'b0;
    pend_load    = 1'b0;
    ev_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        emit = 1'b0;
      end
      S_DISPATCH: begin
        if (out_space) begin
          scan_init = 1'b1;
          case (req_r) inside
            REQ_CREATE, REQ_ACQUIRE, REQ_DEL_HANDLE: begin
              if (!hok_r) begin
                emit     = 1'b1;
                emit_res = make_res(STAT_BAD_HANDLE, '0, 1'b0, '0, 1'b1);
              end
            end
            REQ_RELEASE: begin
              emit = 1'b1;
              if (!rel_ok) begin
                emit_res = make_res(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
              end else if (!busy_r[rel_r]) begin
                emit_res = make_res(STAT_NOT_BUSY, rel_r, 1'b0, '0, 1'b1);
              end else begin
                do_release = 1'b1;
                emit_res   = make_res(STAT_OK, rel_r, 1'b0, '0, 1'b1);
              end
            end
            REQ_DEL_OWNER: begin
              emit = 1'b0;
            end
            default: begin
              emit     = 1'b1;
              emit_res = make_res(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
            end
          endcase
        end
      end
      S_SCAN: begin
        if (out_space) begin
          if (scan_end) begin
            // closing result of the walk
            emit = 1'b1;
            case (req_r)
              REQ_CREATE:  emit_res = make_res(STAT_FULL, '0, 1'b0, '0, 1'b1);
              REQ_ACQUIRE: emit_res = make_res(saw_busy_r ? STAT_BUSY : STAT_NOT_FOUND,
                                               '0, 1'b0, '0, 1'b1);
              REQ_DEL_OWNER: begin
                if (pend_valid_r) begin
                  emit_res = make_res(STAT_OK, pend_slot_r, 1'b1, pend_handle_r, 1'b1);
                end else begin
                  emit_res = make_res(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
                end
              end
              default: emit_res = make_res(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
            endcase
          end else begin
            case (req_r)
              REQ_CREATE: begin
                if (cr_hit) begin
                  do_remove = 1'b1;
                  ev_load   = 1'b1;
                end else begin
                  cur_inc = 1'b1;
                end
              end
              REQ_ACQUIRE: begin
                if (acq_match && s_busy) begin
                  set_saw_busy = 1'b1;
                  cur_inc      = 1'b1;
                end else if (acq_match) begin
                  do_acquire = 1'b1;
                  emit       = 1'b1;
                  emit_res   = make_res(STAT_OK, scan_slot, 1'b0, '0, 1'b1);
                end else begin
                  cur_inc = 1'b1;
                end
              end
              REQ_DEL_HANDLE: begin
                if (hdl_eq && s_busy) begin
                  emit     = 1'b1;
                  emit_res = make_res(STAT_BUSY, '0, 1'b0, '0, 1'b1);
                end else if (hdl_eq) begin
                  do_remove = 1'b1;
                  emit      = 1'b1;
                  emit_res  = make_res(STAT_OK, scan_slot, 1'b0, '0, 1'b1);
                end else begin
                  cur_inc = 1'b1;
                end
              end
              REQ_DEL_OWNER: begin
                // hold the newest eviction back until it is known to be final
                if (own_hit) begin
                  do_remove = 1'b1;
                  pend_load = 1'b1;
                  if (pend_valid_r) begin
                    emit     = 1'b1;
                    emit_res = make_res(STAT_OK, pend_slot_r, 1'b1, pend_handle_r, 1'b0);
                  end
                end else begin
                  cur_inc = 1'b1;
                end
              end
              default: cur_inc = 1'b1;
            endcase
          end
        end
      end
      S_CREATE: begin
        if (out_space) begin
          do_create = 1'b1;
          emit      = 1'b1;
          emit_res  = make_res(STAT_OK, free_slot, ev_valid_r, ev_handle_r, 1'b1);
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      timeout_r <= TIMEOUT_RESET;
      shift_r   <= SHIFT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_TIMEOUT:   timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
          CFG_TAG_SHIFT: shift_r   <= cfg_wdata[SHIFT_W-1:0];
          default:       shift_r   <= shift_r;
        endcase
      end
    end
  end

  // request capture on input transfer
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      req_r    <= in_req_type;
      handle_r <= in_handle;
      user_r   <= in_owner_user;
      uid_r    <= in_owner_uid;
      now_r    <= in_now_ms;
      rel_r    <= in_release_slot;
      hok_r    <= hok_in;
    end
  end

  // slot flags, age ranks and live count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= '0;
      live_r  <= '0;
      for (int s = 0; s < SESSION_SLOTS; s++) begin
        rank_r[s] <= '0;
      end
    end else begin
      if (do_remove) begin
        for (int s = 0; s < SESSION_SLOTS; s++) begin
          if (valid_r[s] && (rank_r[s] > rank_r[scan_slot])) begin
            rank_r[s] <= rank_r[s] - SLOT_W'(1);
          end
        end
        valid_r[scan_slot] <= 1'b0;
        busy_r[scan_slot]  <= 1'b0;
        rank_r[scan_slot]  <= '0;
        live_r             <= live_r - CNT_W'(1);
      end
      if (do_create) begin
        valid_r[free_slot] <= 1'b1;
        busy_r[free_slot]  <= 1'b0;
        rank_r[free_slot]  <= live_r[SLOT_W-1:0];
        live_r             <= live_r + CNT_W'(1);
      end
      if (do_acquire) busy_r[scan_slot] <= 1'b1;
      if (do_release) busy_r[rel_r]     <= 1'b0;
    end
  end

  // entry payload written on create
  always_ff @(posedge clk) begin
    if (do_create) begin
      ent_handle_r[free_slot] <= handle_r;
      ent_user_r[free_slot]   <= user_r;
      ent_uid_r[free_slot]    <= uid_r;
      ent_start_r[free_slot]  <= now_r;
    end
  end

  // scan cursor and walk flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      saw_busy_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      ev_valid_r   <= 1'b0;
    end else if (scan_init) begin
      cur_r        <= '0;
      saw_busy_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      ev_valid_r   <= 1'b0;
    end else begin
      if (cur_inc)      cur_r        <= cur_r + CNT_W'(1);
      if (set_saw_busy) saw_busy_r   <= 1'b1;
      if (pend_load)    pend_valid_r <= 1'b1;
      if (ev_load)      ev_valid_r   <= 1'b1;
    end
  end

  // walk payload: pending owner eviction and create eviction handle
  always_ff @(posedge clk) begin
    if (scan_init) begin
      ev_handle_r <= '0;
    end else if (ev_load) begin
      ev_handle_r <= s_handle;
    end
    if (pend_load) begin
      pend_slot_r   <= scan_slot;
      pend_handle_r <= s_handle;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= emit_res;
  end

  // ports
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_slot         = out_r.slot;
  assign out_abort_valid  = out_r.abort_valid;
  assign out_abort_handle = out_r.abort_handle;
  assign out_last         = out_r.last;

endmodule

FILE: tb/tb_session_slot_table_timeout_evict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_session_slot_table_timeout_evict: self-checking bench for the session table
// directed requests walk create, eviction, acquire, release and both deletes,
// then randomised phases sweep the timeout and handle tag registers, mostly with
// both channels idling at random; a shadow table predicts every result transfer
// ----------------------------------------------------------------------------
module tb_session_slot_table_timeout_evict;
  import sesstab_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int END_CYCLES     = 20;
  localparam int HANDLE_POOL    = 6;
  localparam int OWNER_POOL     = 3;
  localparam int PRINT_CAP      = 50;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // block inputs, all known from time zero
  logic                  in_valid        = 1'b0;
  logic [REQ_W-1:0]      in_req_type     = '0;
  logic [HANDLE_W-1:0]   in_handle       = '0;
  logic [OWNER_W-1:0]    in_owner_user   = '0;
  logic [OWNER_W-1:0]    in_owner_uid    = '0;
  logic [TIME_W-1:0]     in_now_ms       = '0;
  logic [SLOT_W-1:0]     in_release_slot = '0;
  logic                  out_stall       = 1'b0;
  logic                  cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

  // block outputs
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_abort_valid;
  logic [HANDLE_W-1:0] out_abort_handle;
  logic                out_last;

  session_slot_table_timeout_evict uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_handle        (in_handle),
    .in_owner_user    (in_owner_user),
    .in_owner_uid     (in_owner_uid),
    .in_now_ms        (in_now_ms),
    .in_release_slot  (in_release_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_abort_valid  (out_abort_valid),
    .out_abort_handle (out_abort_handle),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // shadow session table and registers
  logic                 tbl_valid  [SESSION_SLOTS];
  logic                 tbl_busy   [SESSION_SLOTS];
  logic [HANDLE_W-1:0]  tbl_handle [SESSION_SLOTS];
  logic [OWNER_W-1:0]   tbl_user   [SESSION_SLOTS];
  logic [OWNER_W-1:0]   tbl_uid    [SESSION_SLOTS];
  logic [TIME_W-1:0]    tbl_start  [SESSION_SLOTS];
  int                   tbl_rank   [SESSION_SLOTS];
  int                   tbl_live;
  int                   age_list   [SESSION_SLOTS];
  logic [TIMEOUT_W-1:0] cur_timeout;
  logic [SHIFT_W-1:0]   cur_shift;

  result_t replies_due[$];

  // stimulus pools and run controls
  logic [HANDLE_W-1:0] handle_pool [HANDLE_POOL];
  logic [OWNER_W-1:0]  user_pool   [OWNER_POOL];
  logic [OWNER_W-1:0]  uid_pool    [OWNER_POOL];
  logic [TIME_W-1:0]   clock_ms;
  bit                  idle_on;
  bit                  stall_on;
  int                  hold_cycles;

  // run statistics
  int err_count;
  int requests_sent;
  int results_seen;
  int reg_writes;
  int create_evictions;
  int create_refusals;
  int owner_sweeps;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(0, 2);
  endfunction

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  function automatic void queue_reply(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                      logic abort_v, logic [HANDLE_W-1:0] abort_h,
                                      logic last);
    result_t r;
    r.status       = status;
    r.slot         = slot;
    r.abort_valid  = abort_v;
    r.abort_handle = abort_h;
    r.last         = last;
    replies_due.push_back(r);
  endfunction

  function automatic bit tag_ok(logic [HANDLE_W-1:0] h);
    return (h >> cur_shift) != '0;
  endfunction

  function automatic bit owner_match(int s, logic [OWNER_W-1:0] user, logic [OWNER_W-1:0] uid);
    return tbl_user[s] == user && tbl_uid[s] == uid;
  endfunction

  // 65-bit sum, so a carry out never times out
  function automatic bit expired(int s, logic [TIME_W-1:0] now);
    logic [TIME_W:0] limit;
    limit = {1'b0, tbl_start[s]} + {{(TIME_W + 1 - TIMEOUT_W){1'b0}}, cur_timeout};
    return limit < {1'b0, now};
  endfunction

  // fill age_list with live slots, oldest first
  function automatic int list_by_age();
    int n;
    n = 0;
    for (int r = 0; r < SESSION_SLOTS; r++)
      for (int s = 0; s < SESSION_SLOTS; s++)
        if (tbl_valid[s] && tbl_rank[s] == r) begin
          age_list[n] = s;
          n++;
        end
    return n;
  endfunction

  function automatic void drop_slot(int s);
    int r;
    r = tbl_rank[s];
    for (int i = 0; i < SESSION_SLOTS; i++)
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
    tbl_valid[s] = 1'b0;
    tbl_busy[s]  = 1'b0;
    tbl_rank[s]  = 0;
    if (tbl_live > 0) tbl_live--;
  endfunction

  // update the shadow table for one request and queue the replies it causes
  function automatic void apply_request(logic [REQ_W-1:0] req, logic [HANDLE_W-1:0] h,
                                        logic [OWNER_W-1:0] user, logic [OWNER_W-1:0] uid,
                                        logic [TIME_W-1:0] now, logic [SLOT_W-1:0] rel);
    int      n, s, k;
    bit      hit, saw_busy, refused;
    logic [HANDLE_W-1:0] ev_h;
    result_t tail;
    hit      = 1'b0;
    saw_busy = 1'b0;
    refused  = 1'b0;
    ev_h     = '0;
    k        = 0;
    case (req)
      REQ_CREATE: begin
        if (!tag_ok(h)) begin
          queue_reply(STAT_BAD_HANDLE, '0, 1'b0, '0, 1'b1);
        end else begin
          // full table: evict the oldest idle entry of this owner or past its age
          if (tbl_live >= SESSION_SLOTS) begin
            n = list_by_age();
            for (int i = 0; i < n && !hit; i++) begin
              s = age_list[i];
              if (!tbl_busy[s] && (owner_match(s, user, uid) || expired(s, now))) begin
                ev_h = tbl_handle[s];
                drop_slot(s);
                hit = 1'b1;
              end
            end
            refused = !hit;
          end
          if (refused) begin
            create_refusals++;
            queue_reply(STAT_FULL, '0, 1'b0, '0, 1'b1);
          end else begin
            s = 0;
            while (s < SESSION_SLOTS && tbl_valid[s]) s++;
            tbl_valid[s]  = 1'b1;
            tbl_busy[s]   = 1'b0;
            tbl_handle[s] = h;
            tbl_user[s]   = user;
            tbl_uid[s]    = uid;
            tbl_start[s]  = now;
            tbl_rank[s]   = tbl_live;
            tbl_live++;
            if (hit) create_evictions++;
            queue_reply(STAT_OK, SLOT_W'(s), hit, ev_h, 1'b1);
          end
        end
      end
      REQ_ACQUIRE: begin
        if (!tag_ok(h)) begin
          queue_reply(STAT_BAD_HANDLE, '0, 1'b0, '0, 1'b1);
        end else begin
          n = list_by_age();
          for (int i = 0; i < n && !hit; i++) begin
            s = age_list[i];
            if (tbl_handle[s] == h && owner_match(s, user, uid)) begin
              if (tbl_busy[s]) begin
                saw_busy = 1'b1;
              end else begin
                tbl_busy[s] = 1'b1;
                hit = 1'b1;
                queue_reply(STAT_OK, SLOT_W'(s), 1'b0, '0, 1'b1);
              end
            end
          end
          if (!hit) queue_reply(saw_busy ? STAT_BUSY : STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
        end
      end
      REQ_RELEASE: begin
        if (!tbl_valid[rel]) begin
          queue_reply(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
        end else if (!tbl_busy[rel]) begin
          queue_reply(STAT_NOT_BUSY, rel, 1'b0, '0, 1'b1);
        end else begin
          tbl_busy[rel] = 1'b0;
          queue_reply(STAT_OK, rel, 1'b0, '0, 1'b1);
        end
      end
      REQ_DEL_HANDLE: begin
        if (!tag_ok(h)) begin
          queue_reply(STAT_BAD_HANDLE, '0, 1'b0, '0, 1'b1);
        end else begin
          // only the oldest entry with this handle counts
          n = list_by_age();
          for (int i = 0; i < n && !hit; i++) begin
            s = age_list[i];
            if (tbl_handle[s] == h) begin
              hit = 1'b1;
              if (tbl_busy[s]) begin
                queue_reply(STAT_BUSY, '0, 1'b0, '0, 1'b1);
              end else begin
                drop_slot(s);
                queue_reply(STAT_OK, SLOT_W'(s), 1'b0, '0, 1'b1);
              end
            end
          end
          if (!hit) queue_reply(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
        end
      end
      REQ_DEL_OWNER: begin
        // one abort per idle entry of this owner, oldest first
        n = list_by_age();
        for (int i = 0; i < n && k < SESSION_SLOTS; i++) begin
          s = age_list[i];
          if (!tbl_busy[s] && owner_match(s, user, uid)) begin
            queue_reply(STAT_OK, SLOT_W'(s), 1'b1, tbl_handle[s], 1'b0);
            drop_slot(s);
            k++;
          end
        end
        if (k == 0) begin
          queue_reply(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
        end else begin
          tail      = replies_due.pop_back();
          tail.last = 1'b1;
          replies_due.push_back(tail);
          if (k > 1) owner_sweeps++;
        end
      end
      default: begin
        queue_reply(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request transfer; the shadow table is updated at acceptance
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [HANDLE_W-1:0] h,
                          input logic [OWNER_W-1:0] user, input logic [OWNER_W-1:0] uid,
                          input logic [TIME_W-1:0] now, input logic [SLOT_W-1:0] rel);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_handle       <= h;
    in_owner_user   <= user;
    in_owner_uid    <= uid;
    in_now_ms       <= now;
    in_release_slot <= rel;
    do @(posedge clk); while (in_stall);
    apply_request(req, h, user, uid, now, rel);
    requests_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TIMEOUT) cur_timeout = data[TIMEOUT_W-1:0];
    else                    cur_shift   = data[SHIFT_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // new handles valid under the current tag shift, and new owners
  task automatic refresh_pools();
    logic [HANDLE_W-1:0] h;
    handle_pool[0] = '1;
    handle_pool[1] = HANDLE_W'(1) << cur_shift;
    for (int i = 2; i < HANDLE_POOL; i++) begin
      h = {$urandom, $urandom};
      h[cur_shift] = 1'b1;
      handle_pool[i] = h;
    end
    for (int i = 0; i < OWNER_POOL; i++) begin
      user_pool[i] = $urandom;
      uid_pool[i]  = $urandom;
    end
  endtask

  // random request, mostly on pooled handles and owners so entries collide
  task automatic rand_request();
    int                  pick, o;
    logic [REQ_W-1:0]    req;
    logic [HANDLE_W-1:0] h;
    logic [OWNER_W-1:0]  user, uid;
    logic [TIME_W-1:0]   now;
    pick = $urandom_range(0, 99);
    if      (pick < 32) req = REQ_CREATE;
    else if (pick < 52) req = REQ_ACQUIRE;
    else if (pick < 66) req = REQ_RELEASE;
    else if (pick < 80) req = REQ_DEL_HANDLE;
    else if (pick < 95) req = REQ_DEL_OWNER;
    else                req = REQ_DEL_OWNER + REQ_W'($urandom_range(1, 3));
    h = ($urandom_range(0, 99) < 85) ? handle_pool[$urandom_range(0, HANDLE_POOL - 1)]
                                     : {$urandom, $urandom};
    o = $urandom_range(0, OWNER_POOL - 1);
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      user = user_pool[o];
      uid  = uid_pool[o];
    end else if (pick < 92) begin
      // same user, other uid
      user = user_pool[o];
      uid  = uid_pool[(o + 1) % OWNER_POOL];
    end else begin
      user = $urandom;
      uid  = $urandom;
    end
    clock_ms += ($urandom_range(0, 15) == 0) ? TIME_W'($urandom_range(1000, 200000))
                                             : TIME_W'($urandom_range(0, 40));
    now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_ms;
    send_req(req, h, user, uid, now, SLOT_W'($urandom_range(0, SESSION_SLOTS - 1)));
  endtask

  task automatic run_phase(input logic [TIMEOUT_W-1:0] tmo, input logic [SHIFT_W-1:0] shift,
                           input int count, input bit idling);
    drain_replies();
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    write_reg(CFG_TAG_SHIFT, CFG_DATA_W'(shift));
    refresh_pools();
    idle_on  = idling;
    stall_on = idling;
    repeat (count) rand_request();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                 input logic [HANDLE_W-1:0] want);
    if (err_count < PRINT_CAP)
      $display("%0t mismatch on %s: got %0h, want %0h (result %0d)",
               $realtime, what, got, want, results_seen);
    err_count++;
  endtask

  // receiver stalls: random short and long stretches, or one long hold on request
  initial begin : out_backpressure
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        for (n = 0; n < hold_cycles; n++) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result transfer with the oldest reply due
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("result with none due", out_status, '0);
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_slot !== want.slot)
          report_mismatch("slot", out_slot, want.slot);
        if (out_abort_valid !== want.abort_valid)
          report_mismatch("abort_valid", out_abort_valid, want.abort_valid);
        if (out_abort_handle !== want.abort_handle)
          report_mismatch("abort_handle", out_abort_handle, want.abort_handle);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results due",
             WATCHDOG_LIMIT, replies_due.size());
    $display("** session_slot_table_timeout_evict: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  localparam logic [HANDLE_W-1:0] H1 = 64'h0000_0001_0000_0001;
  localparam logic [HANDLE_W-1:0] H2 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [HANDLE_W-1:0] H3 = 64'h8000_0000_0000_0000;
  localparam logic [HANDLE_W-1:0] H4 = 64'h0000_0001_FFFF_FFFF;
  localparam logic [OWNER_W-1:0]  OW_LO = 32'h0000_0000;
  localparam logic [OWNER_W-1:0]  OW_HI = 32'hFFFF_FFFF;

  // fill, refuse, evict by owner, evict by age
  task automatic test_create_evict();
    send_req(REQ_CREATE, 64'h0000_0000_FFFF_FFFF, OW_LO, OW_LO, 0, 0);
    send_req(REQ_CREATE, H1, OW_LO, OW_LO, 0,  0);
    send_req(REQ_CREATE, H2, OW_HI, OW_HI, 10, 0);
    send_req(REQ_CREATE, H3, OW_LO, OW_LO, 20, 0);
    send_req(REQ_CREATE, H4, OW_HI, OW_HI, 30, 0);
    send_req(REQ_CREATE, H1, 1, 2, 40, 0);
    send_req(REQ_CREATE, H2, OW_HI, OW_HI, 50, 0);
    send_req(REQ_CREATE, H3, 1, 2, 200000, 0);
  endtask

  // acquire hit, busy, owner miss, bad handle; release busy and idle entries
  task automatic test_acquire_release();
    send_req(REQ_ACQUIRE, H4, OW_HI, OW_HI, 0, 0);
    send_req(REQ_ACQUIRE, H4, OW_HI, OW_HI, 0, 0);
    send_req(REQ_ACQUIRE, H4, OW_LO, OW_LO, 0, 0);
    send_req(REQ_ACQUIRE, '0, OW_HI, OW_HI, 0, 0);
    send_req(REQ_RELEASE, H4, OW_HI, OW_HI, 0, 3);
    send_req(REQ_RELEASE, H4, OW_HI, OW_HI, 0, 3);
    send_req(REQ_ACQUIRE, H3, OW_LO, OW_LO, 0, 0);
  endtask

  // delete by handle on a busy oldest entry, owner sweep, free slot release
  task automatic test_delete();
    send_req(REQ_DEL_HANDLE, H3, OW_LO, OW_LO, 0, 0);
    send_req(REQ_DEL_HANDLE, '0, OW_LO, OW_LO, 0, 0);
    send_req(REQ_RELEASE,    H3, OW_LO, OW_LO, 0, 2);
    send_req(REQ_DEL_OWNER,  '0, OW_HI, OW_HI, 0, 0);
    send_req(REQ_RELEASE,    '0, OW_HI, OW_HI, 0, 1);
    send_req(REQ_DEL_OWNER,  '0, OW_HI, OW_HI, 0, 0);
    send_req(REQ_DEL_HANDLE, H3, OW_LO, OW_LO, 0, 0);
    send_req(REQ_DEL_OWNER + REQ_W'(3), H1, OW_LO, OW_LO, 0, 3);
  endtask

  // start times near the top of the clock: the age sum carries, nothing expires
  task automatic test_time_carry();
    send_req(REQ_DEL_OWNER, '0, 1, 2, 0, 0);
    for (int i = 0; i < SESSION_SLOTS; i++)
      send_req(REQ_CREATE, H1 + i, 32'h1234, 32'h5, 64'hFFFF_FFFF_FFFF_0000 + i, 0);
    send_req(REQ_CREATE, H2, 32'h7, 32'h8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
  endtask

  // register extremes and mid values, with and without idling
  task automatic test_config_sweep();
    run_phase(0, 0, 60, 1'b1);
    run_phase(32'hFFFF_FFFF, 63, 60, 1'b1);
    run_phase(50, 32, 60, 1'b0);
    run_phase(TIMEOUT_W'($urandom_range(0, 2000)), SHIFT_W'($urandom_range(0, 63)), 70, 1'b1);
  endtask

  // long receiver hold while requests keep coming, so the block stalls its input
  task automatic test_backpressure();
    drain_replies();
    stall_on = 1'b0;
    write_reg(CFG_TIMEOUT, 1000);
    write_reg(CFG_TAG_SHIFT, 16);
    refresh_pools();
    idle_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (30) rand_request();
  endtask

  task automatic test_random_mix();
    run_phase(TIMEOUT_RESET, 40, 120, 1'b1);
  endtask

  initial begin : main
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_busy[i]   = 1'b0;
      tbl_rank[i]   = 0;
      tbl_handle[i] = '0;
      tbl_user[i]   = '0;
      tbl_uid[i]    = '0;
      tbl_start[i]  = '0;
    end
    tbl_live         = 0;
    cur_timeout      = TIMEOUT_RESET;
    cur_shift        = SHIFT_RESET;
    clock_ms         = '0;
    idle_on          = 1'b1;
    stall_on         = 1'b1;
    hold_cycles      = 0;
    err_count        = 0;
    requests_sent    = 0;
    results_seen     = 0;
    reg_writes       = 0;
    create_evictions = 0;
    create_refusals  = 0;
    owner_sweeps     = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_create_evict();
    test_acquire_release();
    test_delete();
    test_time_carry();
    test_config_sweep();
    test_backpressure();
    test_random_mix();

    // let the last results come out, then watch for strays
    drain_replies();
    repeat (END_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) report_mismatch("results still due", replies_due.size(), 0);

    $display("covered %0d requests, %0d results, %0d register writes",
             requests_sent, results_seen, reg_writes);
    $display("create evictions %0d, create refusals %0d, multi-abort owner deletes %0d",
             create_evictions, create_refusals, owner_sweeps);
    if (err_count == 0) begin
      $display("** session_slot_table_timeout_evict: PASSED **");
    end else begin
      $display("%0d mismatches", err_count);
      $display("** session_slot_table_timeout_evict: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sesstab_pkg.sv
hw/rtl/session_slot_table_timeout_evict.sv
tb/tb_session_slot_table_timeout_evict.sv
